// ===== design/sfp_pkg.sv =====
// Shared types and constants for the sample-frame placement block.
package sfp_pkg;

  localparam int STATION_W = 8;
  localparam int BOARD_W   = 4;
  localparam int CHANNEL_W = 3;
  localparam int FREQ_W    = 10;
  localparam int WORD_W    = 32;
  localparam int BANDS_W   = 16;
  localparam int BYTES_W   = 13;
  localparam int COUNT_W   = 12;
  localparam int OFFSET_W  = 62;
  localparam int MASK_W    = 64;
  localparam int SCALE_W   = 20;
  localparam int KFREQ_W   = FREQ_W + SCALE_W;
  localparam int PROD_W    = WORD_W + KFREQ_W;

  typedef logic [1:0] status_t;

  localparam status_t STATUS_PLACED   = 2'd0;
  localparam status_t STATUS_SHORT    = 2'd1;
  localparam status_t STATUS_UNKNOWN  = 2'd2;
  localparam status_t STATUS_NEGATIVE = 2'd3;

  localparam logic [FREQ_W-1:0]  TRANSIENT_FREQ_MHZ  = 10'd200;
  localparam logic [WORD_W-1:0]  ODD_SECOND_STEP     = 32'd512;
  localparam logic [SCALE_W-1:0] FREQ_SCALE          = 20'd1000000;
  localparam logic [BYTES_W-1:0] MIN_TRANSIENT_BYTES = 13'd6;
  localparam logic [BYTES_W-1:0] MIN_SPECTRAL_BYTES  = 13'd2;
  localparam logic [BYTES_W-1:0] TRANSIENT_HDR_BYTES = 13'd4;

endpackage

// ===== design/sfp_hdr_if.sv =====
// Channel that carries one received sample-frame header per item.
interface sfp_hdr_if;
  logic                              valid;
  logic                              ready;
  logic [sfp_pkg::STATION_W-1:0]     station_id;
  logic [sfp_pkg::BOARD_W-1:0]       board_id;
  logic [sfp_pkg::CHANNEL_W-1:0]     channel_id;
  logic [sfp_pkg::FREQ_W-1:0]        sample_freq_mhz;
  logic [sfp_pkg::WORD_W-1:0]        time_seconds;
  logic [sfp_pkg::WORD_W-1:0]        sample_nr;
  logic [sfp_pkg::BANDS_W-1:0]       freq_bands;
  logic [sfp_pkg::BYTES_W-1:0]       payload_bytes;

  modport source (
    output valid, station_id, board_id, channel_id, sample_freq_mhz,
           time_seconds, sample_nr, freq_bands, payload_bytes,
    input  ready
  );
  modport sink (
    input  valid, station_id, board_id, channel_id, sample_freq_mhz,
           time_seconds, sample_nr, freq_bands, payload_bytes,
    output ready
  );
endinterface

// ===== design/sfp_res_if.sv =====
// Channel that carries one placement result per item.
interface sfp_res_if;
  logic                          valid;
  logic                          ready;
  sfp_pkg::status_t              status;
  logic                          new_stream;
  logic [sfp_pkg::COUNT_W-1:0]   sample_count;
  logic [sfp_pkg::WORD_W-1:0]    fixed_sample_nr;
  logic [sfp_pkg::OFFSET_W-1:0]  byte_offset;

  modport source (
    output valid, status, new_stream, sample_count, fixed_sample_nr, byte_offset,
    input  ready
  );
  modport sink (
    input  valid, status, new_stream, sample_count, fixed_sample_nr, byte_offset,
    output ready
  );
endinterface

// ===== design/sfp_cfg_if.sv =====
// Write channel for the known-station mask register.
interface sfp_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [sfp_pkg::MASK_W-1:0]   data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

// ===== design/sfp_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
module sfp_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 2,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/sample_frame_placement.sv =====
// Sample-frame placement: checks headers, tracks streams and computes byte offsets.
//
//   channel | role   | carries
//   --------+--------+------------------------------------------------
//   hdr     | sink   | one sample-frame header per item
//   res     | source | status, new stream flag, count, sample nr, offset
//   cfg     | sink   | known-station mask, always ready
//
// Each header passes through RAM lookup, difference and frequency scaling,
// one 32x30 multiply, then the final add into the output register.
// Reset starts a clearing pass over the stream memory that covers
// STATION_SLOTS*BOARDS_PER_STATION*CHANNELS_PER_BOARD entries (8192 by default);
// no header is taken during it. A stalled output holds the block in its
// last step; the output register lets the next header in while a result waits.
module sample_frame_placement #(
  parameter int STATION_SLOTS      = 64,
  parameter int BOARDS_PER_STATION = 16,
  parameter int CHANNELS_PER_BOARD = 8
) (
  input  logic        clk,
  input  logic        rst,
  sfp_hdr_if.sink     hdr,
  sfp_res_if.source   res,
  sfp_cfg_if.sink     cfg
);
  import sfp_pkg::*;

  localparam int STREAM_DEPTH = STATION_SLOTS * BOARDS_PER_STATION * CHANNELS_PER_BOARD;
  localparam int SEEN_AW = (STREAM_DEPTH > 1) ? $clog2(STREAM_DEPTH) : 1;
  localparam int ST_AW   = (STATION_SLOTS > 1) ? $clog2(STATION_SLOTS) : 1;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_LOOK  = 3'd2;
  localparam logic [2:0] S_MUL   = 3'd3;
  localparam logic [2:0] S_FIN   = 3'd4;

  logic [2:0]          state;
  logic [SEEN_AW-1:0]  clr_cnt;
  logic [MASK_W-1:0]   mask;

  logic [STATION_W-1:0] station_r;
  logic [BOARD_W-1:0]   board_r;
  logic [CHANNEL_W-1:0] channel_r;
  logic [FREQ_W-1:0]    freq_r;
  logic [WORD_W-1:0]    tsec_r;
  logic [WORD_W-1:0]    fixed_r;
  logic [COUNT_W-1:0]   count_r;
  logic                 short_r;
  logic [SEEN_AW-1:0]   seen_addr_r;

  logic                 unknown_r;
  logic                 fresh_r;
  logic                 neg_r;
  logic [WORD_W-1:0]    mag_r;
  logic [WORD_W:0]      ds_r;
  logic [KFREQ_W-1:0]   k_r;
  logic [PROD_W-1:0]    prod_r;

  logic                 res_valid;
  status_t              res_status;
  logic                 res_new;
  logic [COUNT_W-1:0]   res_count;
  logic [WORD_W-1:0]    res_fixed;
  logic [OFFSET_W-1:0]  res_offset;

  logic                 transient_in;
  logic                 short_in;
  logic [BYTES_W-1:0]   count_full;
  logic [WORD_W-1:0]    fixed_in;
  logic [31:0]          idx_in;
  logic                 hdr_take;

  logic                 seen_we;
  logic [SEEN_AW-1:0]   seen_waddr;
  logic [0:0]           seen_wdata;
  logic [0:0]           seen_rdata;
  logic [2*WORD_W-1:0]  base_rdata;
  logic                 base_we;

  logic                 unknown_c;
  logic                 fresh_c;
  logic [WORD_W-1:0]    base_t;
  logic [WORD_W-1:0]    base_s;
  logic [WORD_W:0]      d_fwd;
  logic [WORD_W:0]      d_bwd;
  logic [WORD_W:0]      ds_c;
  logic [KFREQ_W-1:0]   k_c;

  logic [63:0]          ds_ext;
  logic [63:0]          prod_ext;
  logic [63:0]          sum_c;
  logic                 out_free;

  assign hdr.ready = (state == S_IDLE);
  assign cfg.ready = 1'b1;
  assign hdr_take  = hdr.valid && hdr.ready;

  assign res.valid           = res_valid;
  assign res.status          = res_status;
  assign res.new_stream      = res_new;
  assign res.sample_count    = res_count;
  assign res.fixed_sample_nr = res_fixed;
  assign res.byte_offset     = res_offset;

  always_comb begin
    transient_in = (hdr.freq_bands == '0);
    if (transient_in) begin
      short_in   = hdr.payload_bytes < MIN_TRANSIENT_BYTES;
      count_full = (hdr.payload_bytes - TRANSIENT_HDR_BYTES) >> 1;
    end else begin
      short_in   = hdr.payload_bytes < MIN_SPECTRAL_BYTES;
      count_full = hdr.payload_bytes >> 2;
    end
    if (transient_in && hdr.sample_freq_mhz == TRANSIENT_FREQ_MHZ && hdr.time_seconds[0]) begin
      fixed_in = hdr.sample_nr + ODD_SECOND_STEP;
    end else begin
      fixed_in = hdr.sample_nr;
    end
    idx_in = (32'(hdr.station_id) * 32'(BOARDS_PER_STATION) + 32'(hdr.board_id))
             * 32'(CHANNELS_PER_BOARD) + 32'(hdr.channel_id);
  end

  always_comb begin
    unknown_c = ({1'b0, station_r} >= 9'(STATION_SLOTS))
             || ({1'b0, board_r} >= 5'(BOARDS_PER_STATION))
             || ({1'b0, channel_r} >= 4'(CHANNELS_PER_BOARD))
             || !mask[station_r[5:0]];
    fresh_c = !seen_rdata[0];
    base_t  = base_rdata[2*WORD_W-1:WORD_W];
    base_s  = base_rdata[WORD_W-1:0];
    d_fwd   = {1'b0, tsec_r} - {1'b0, base_t};
    d_bwd   = {1'b0, base_t} - {1'b0, tsec_r};
    ds_c    = {1'b0, fixed_r} - {1'b0, base_s};
    k_c     = KFREQ_W'(freq_r) * KFREQ_W'(FREQ_SCALE);
  end

  assign base_we = (state == S_LOOK) && !short_r && !unknown_c && fresh_c;

  always_comb begin
    if (state == S_CLEAR) begin
      seen_we    = 1'b1;
      seen_waddr = clr_cnt;
      seen_wdata = 1'b0;
    end else begin
      seen_we    = base_we;
      seen_waddr = seen_addr_r;
      seen_wdata = 1'b1;
    end
  end

  sfp_ram #(.WIDTH(1), .DEPTH(STREAM_DEPTH)) u_seen_ram (
    .clk   (clk),
    .we    (seen_we),
    .waddr (seen_waddr),
    .wdata (seen_wdata),
    .raddr (idx_in[SEEN_AW-1:0]),
    .rdata (seen_rdata)
  );

  sfp_ram #(.WIDTH(2*WORD_W), .DEPTH(STATION_SLOTS)) u_base_ram (
    .clk   (clk),
    .we    (base_we),
    .waddr (station_r[ST_AW-1:0]),
    .wdata ({tsec_r, fixed_r}),
    .raddr (hdr.station_id[ST_AW-1:0]),
    .rdata (base_rdata)
  );

  always_comb begin
    ds_ext   = {{(63-WORD_W){ds_r[WORD_W]}}, ds_r};
    prod_ext = {{(64-PROD_W){1'b0}}, prod_r};
    sum_c    = neg_r ? (ds_ext - prod_ext) : (ds_ext + prod_ext);
    out_free = !res_valid || res.ready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_cnt   <= '0;
      mask      <= '0;
      res_valid <= 1'b0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        mask <= cfg.data;
      end
      if (state == S_FIN && out_free) begin
        res_valid <= 1'b1;
      end else if (res_valid && res.ready) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == SEEN_AW'(STREAM_DEPTH - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (hdr_take) begin
            state <= S_LOOK;
          end
        end
        S_LOOK: state <= S_MUL;
        S_MUL:  state <= S_FIN;
        S_FIN: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_CLEAR;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (hdr_take) begin
      station_r   <= hdr.station_id;
      board_r     <= hdr.board_id;
      channel_r   <= hdr.channel_id;
      freq_r      <= hdr.sample_freq_mhz;
      tsec_r      <= hdr.time_seconds;
      fixed_r     <= fixed_in;
      count_r     <= count_full[COUNT_W-1:0];
      short_r     <= short_in;
      seen_addr_r <= idx_in[SEEN_AW-1:0];
    end
    if (state == S_LOOK) begin
      unknown_r <= unknown_c;
      fresh_r   <= fresh_c;
      k_r       <= k_c;
      if (fresh_c) begin
        neg_r <= 1'b0;
        mag_r <= '0;
        ds_r  <= '0;
      end else begin
        neg_r <= d_fwd[WORD_W];
        mag_r <= d_fwd[WORD_W] ? d_bwd[WORD_W-1:0] : d_fwd[WORD_W-1:0];
        ds_r  <= ds_c;
      end
    end
    if (state == S_MUL) begin
      prod_r <= PROD_W'(mag_r) * PROD_W'(k_r);
    end
    if (state == S_FIN && out_free) begin
      if (short_r) begin
        res_status <= STATUS_SHORT;
        res_new    <= 1'b0;
        res_count  <= '0;
        res_fixed  <= '0;
        res_offset <= '0;
      end else if (unknown_r) begin
        res_status <= STATUS_UNKNOWN;
        res_new    <= 1'b0;
        res_count  <= count_r;
        res_fixed  <= fixed_r;
        res_offset <= '0;
      end else if (sum_c[62]) begin
        res_status <= STATUS_NEGATIVE;
        res_new    <= fresh_r;
        res_count  <= count_r;
        res_fixed  <= fixed_r;
        res_offset <= '0;
      end else begin
        res_status <= STATUS_PLACED;
        res_new    <= fresh_r;
        res_count  <= count_r;
        res_fixed  <= fixed_r;
        res_offset <= {sum_c[OFFSET_W-2:0], 1'b0};
      end
    end
  end

endmodule

// ===== design/sfp_checker.sv =====
// Port-level checker for the sample-frame placement block and its bind.
module sfp_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         hdr_valid,
  input logic                         hdr_ready,
  input logic                         res_valid,
  input logic                         res_ready,
  input sfp_pkg::status_t             res_status,
  input logic                         res_new,
  input logic [sfp_pkg::COUNT_W-1:0]  res_count,
  input logic [sfp_pkg::WORD_W-1:0]   res_fixed,
  input logic [sfp_pkg::OFFSET_W-1:0] res_offset
);
  import sfp_pkg::*;

  // Only one header is in flight at a time.
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    hdr_valid && hdr_ready |=> !hdr_ready)
    else $error("header accepted while another is in flight");

  a_short_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_status == STATUS_SHORT |->
      !res_new && res_count == '0 && res_fixed == '0 && res_offset == '0)
    else $error("short frame result carries nonzero fields");

  a_drop_offset: assert property (@(posedge clk) disable iff (rst)
    res_valid && (res_status == STATUS_UNKNOWN || res_status == STATUS_NEGATIVE) |->
      res_offset == '0 && (res_status == STATUS_NEGATIVE || !res_new))
    else $error("dropped or negative result carries an offset or new stream flag");

  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_status) && $stable(res_new)
      && $stable(res_count) && $stable(res_fixed) && $stable(res_offset))
    else $error("stalled result changed");

endmodule

bind sample_frame_placement sfp_checker u_sfp_checker (
  .clk        (clk),
  .rst        (rst),
  .hdr_valid  (hdr.valid),
  .hdr_ready  (hdr.ready),
  .res_valid  (res.valid),
  .res_ready  (res.ready),
  .res_status (res.status),
  .res_new    (res.new_stream),
  .res_count  (res.sample_count),
  .res_fixed  (res.fixed_sample_nr),
  .res_offset (res.byte_offset)
);

// ===== test/frame_placement_monitor.sv =====
`timescale 1ns / 1ps
// Monitor that predicts each frame placement from the accepted headers and checks every result.
module frame_placement_monitor #(
  parameter int STATION_SLOTS      = 64,
  parameter int BOARDS_PER_STATION = 16,
  parameter int CHANNELS_PER_BOARD = 8
) (
  input  logic clk,
  input  logic rst,
  sfp_hdr_if   hdr,
  sfp_res_if   res,
  sfp_cfg_if   cfg,
  output int   fail_count,
  output int   pending,
  output int   checked,
  output int   fresh_streams,
  output int   negatives
);
  import sfp_pkg::*;

  localparam int STREAM_DEPTH = STATION_SLOTS * BOARDS_PER_STATION * CHANNELS_PER_BOARD;

  typedef struct packed {
    status_t               status;
    logic                  new_stream;
    logic [COUNT_W-1:0]    count;
    logic [WORD_W-1:0]     fixed;
    logic [OFFSET_W-1:0]   offset;
  } placement_t;

  logic [MASK_W-1:0] station_mask;
  logic [WORD_W-1:0] base_time   [STATION_SLOTS];
  logic [WORD_W-1:0] base_sample [STATION_SLOTS];
  logic              stream_open [STREAM_DEPTH];
  placement_t        placements_due [$];
  placement_t        want;
  int                errs;
  int                nchecked;
  int                nfresh;
  int                nneg;

  initial begin
    errs = 0;
    nchecked = 0;
    nfresh = 0;
    nneg = 0;
    fail_count = 0;
    pending = 0;
    checked = 0;
    fresh_streams = 0;
    negatives = 0;
  end

  function automatic placement_t place_frame(
    input logic [STATION_W-1:0] station,
    input logic [BOARD_W-1:0]   board,
    input logic [CHANNEL_W-1:0] channel,
    input logic [FREQ_W-1:0]    freq,
    input logic [WORD_W-1:0]    ts,
    input logic [WORD_W-1:0]    sn,
    input logic [BANDS_W-1:0]   bands,
    input logic [BYTES_W-1:0]   bytes
  );
    placement_t        p;
    logic [WORD_W-1:0] fixed;
    logic [63:0]       dt;
    logic [63:0]       ds;
    logic [63:0]       off;
    int                idx;
    p = '0;
    fixed = sn;
    if (bands == '0) begin
      if (bytes < MIN_TRANSIENT_BYTES) begin
        p.status = STATUS_SHORT;
        return p;
      end
      p.count = COUNT_W'((bytes - TRANSIENT_HDR_BYTES) >> 1);
      if (freq == TRANSIENT_FREQ_MHZ && ts[0]) fixed = sn + ODD_SECOND_STEP;
    end else begin
      if (bytes < MIN_SPECTRAL_BYTES) begin
        p.status = STATUS_SHORT;
        return p;
      end
      p.count = COUNT_W'(bytes >> 2);
    end
    p.fixed = fixed;
    if (int'(station) >= STATION_SLOTS || int'(board) >= BOARDS_PER_STATION ||
        int'(channel) >= CHANNELS_PER_BOARD || !station_mask[station]) begin
      p.status = STATUS_UNKNOWN;
      return p;
    end
    idx = (int'(station) * BOARDS_PER_STATION + int'(board)) * CHANNELS_PER_BOARD
          + int'(channel);
    if (!stream_open[idx]) begin
      stream_open[idx] = 1'b1;
      base_time[station] = ts;
      base_sample[station] = fixed;
      p.new_stream = 1'b1;
    end
    dt = 64'(ts) - 64'(base_time[station]);
    ds = 64'(fixed) - 64'(base_sample[station]);
    off = (dt * 64'(freq) * 64'(FREQ_SCALE) + ds) * 64'd2;
    if (off[63]) begin
      p.status = STATUS_NEGATIVE;
    end else begin
      p.status = STATUS_PLACED;
      p.offset = off[OFFSET_W-1:0];
    end
    return p;
  endfunction

  task automatic check_field(input string name, input logic [63:0] exp_v,
                             input logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected 0x%0h, actual 0x%0h", name, exp_v, act_v);
      errs++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      station_mask = '0;
      for (int s = 0; s < STATION_SLOTS; s++) begin
        base_time[s] = '0;
        base_sample[s] = '0;
      end
      for (int i = 0; i < STREAM_DEPTH; i++) stream_open[i] = 1'b0;
      placements_due.delete();
    end else begin
      if (cfg.valid && cfg.ready) station_mask = cfg.data;
      if (res.valid && res.ready) begin
        if (placements_due.size() == 0) begin
          $error("result item arrived with no header waiting for it");
          errs++;
        end else begin
          want = placements_due.pop_front();
          check_field("status", 64'(want.status), 64'(res.status));
          check_field("new_stream", 64'(want.new_stream), 64'(res.new_stream));
          check_field("sample_count", 64'(want.count), 64'(res.sample_count));
          check_field("fixed_sample_nr", 64'(want.fixed), 64'(res.fixed_sample_nr));
          check_field("byte_offset", 64'(want.offset), 64'(res.byte_offset));
          nchecked++;
          if (want.new_stream) nfresh++;
          if (want.status == STATUS_NEGATIVE) nneg++;
        end
      end
      if (hdr.valid && hdr.ready) begin
        placements_due.insert(placements_due.size(),
                              place_frame(hdr.station_id, hdr.board_id, hdr.channel_id,
                                          hdr.sample_freq_mhz, hdr.time_seconds,
                                          hdr.sample_nr, hdr.freq_bands,
                                          hdr.payload_bytes));
      end
    end
    fail_count <= errs;
    pending <= placements_due.size();
    checked <= nchecked;
    fresh_streams <= nfresh;
    negatives <= nneg;
  end

endmodule

// ===== test/tb_sample_frame_placement.sv =====
`timescale 1ns / 1ps
// Testbench top for the sample-frame placement block: stimulus, idling mixes and verdict.
module tb_sample_frame_placement;
  import sfp_pkg::*;

  localparam int STALL_LIMIT      = 40000;
  localparam int RANDOM_PER_PHASE = 330;

  typedef struct packed {
    logic [STATION_W-1:0] station;
    logic [BOARD_W-1:0]   board;
    logic [CHANNEL_W-1:0] channel;
    logic [FREQ_W-1:0]    freq;
    logic [WORD_W-1:0]    ts;
    logic [WORD_W-1:0]    sn;
    logic [BANDS_W-1:0]   bands;
    logic [BYTES_W-1:0]   bytes;
  } frame_t;

  logic              clk;
  logic              rst;
  int                hdr_idle;
  int                res_idle;
  int                sent;
  int                directed_count;
  int                masks_written;
  int                stall_cycles;
  int                fail_count;
  int                pending;
  int                checked;
  int                fresh_streams;
  int                negatives;
  logic [WORD_W-1:0] now_sec;
  logic [MASK_W-1:0] phase_mask [3];

  sfp_hdr_if hdr ();
  sfp_res_if res ();
  sfp_cfg_if cfg ();

  sample_frame_placement dut (
    .clk (clk),
    .rst (rst),
    .hdr (hdr),
    .res (res),
    .cfg (cfg)
  );

  frame_placement_monitor u_monitor (
    .clk           (clk),
    .rst           (rst),
    .hdr           (hdr),
    .res           (res),
    .cfg           (cfg),
    .fail_count    (fail_count),
    .pending       (pending),
    .checked       (checked),
    .fresh_streams (fresh_streams),
    .negatives     (negatives)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  always @(negedge clk) begin
    res.ready <= ($urandom_range(0, 99) >= res_idle);
  end

  always @(posedge clk) begin
    if (rst || (hdr.valid && hdr.ready) || (res.valid && res.ready) ||
        (cfg.valid && cfg.ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles + 1 >= STALL_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  function automatic frame_t make_frame(
    input logic [STATION_W-1:0] station,
    input logic [BOARD_W-1:0]   board,
    input logic [CHANNEL_W-1:0] channel,
    input logic [FREQ_W-1:0]    freq,
    input logic [WORD_W-1:0]    ts,
    input logic [WORD_W-1:0]    sn,
    input logic [BANDS_W-1:0]   bands,
    input logic [BYTES_W-1:0]   bytes
  );
    frame_t f;
    f.station = station;
    f.board = board;
    f.channel = channel;
    f.freq = freq;
    f.ts = ts;
    f.sn = sn;
    f.bands = bands;
    f.bytes = bytes;
    return f;
  endfunction

  function automatic frame_t random_frame();
    frame_t f;
    int     pick;
    pick = $urandom_range(0, 99);
    if (pick < 6) f.station = STATION_W'($urandom);
    else if (pick < 30) f.station = STATION_W'($urandom_range(0, 63));
    else f.station = STATION_W'($urandom_range(0, 7));
    f.board = ($urandom_range(0, 3) == 0) ? BOARD_W'($urandom) : BOARD_W'($urandom_range(0, 1));
    f.channel = ($urandom_range(0, 3) == 0) ? CHANNEL_W'($urandom)
                                            : CHANNEL_W'($urandom_range(0, 1));
    pick = $urandom_range(0, 99);
    if (pick < 45) f.freq = TRANSIENT_FREQ_MHZ;
    else if (pick < 55) f.freq = '1;
    else if (pick < 60) f.freq = '0;
    else f.freq = FREQ_W'($urandom);
    now_sec = now_sec + $urandom_range(0, 1);
    pick = $urandom_range(0, 99);
    if (pick < 10) f.ts = $urandom;
    else if (pick < 25) f.ts = now_sec + $urandom_range(0, 2) - 3;
    else f.ts = now_sec + $urandom_range(0, 2);
    f.sn = $urandom_range(0, 1) ? $urandom : $urandom_range(0, 200000);
    f.bands = ($urandom_range(0, 9) < 6) ? '0 : BANDS_W'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 8) f.bytes = BYTES_W'($urandom_range(0, 7));
    else if (pick < 13) f.bytes = BYTES_W'($urandom);
    else f.bytes = BYTES_W'($urandom_range(6, 1100));
    return f;
  endfunction

  task automatic send_frame(input frame_t f);
    while ($urandom_range(0, 99) < hdr_idle) begin
      hdr.valid <= 1'b0;
      @(negedge clk);
    end
    hdr.valid <= 1'b1;
    hdr.station_id <= f.station;
    hdr.board_id <= f.board;
    hdr.channel_id <= f.channel;
    hdr.sample_freq_mhz <= f.freq;
    hdr.time_seconds <= f.ts;
    hdr.sample_nr <= f.sn;
    hdr.freq_bands <= f.bands;
    hdr.payload_bytes <= f.bytes;
    @(posedge clk);
    while (!hdr.ready) @(posedge clk);
    sent++;
    @(negedge clk);
  endtask

  task automatic drain(input int extra);
    hdr.valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_mask(input logic [MASK_W-1:0] m);
    cfg.valid <= 1'b1;
    cfg.data <= m;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    masks_written++;
    @(negedge clk);
    cfg.valid <= 1'b0;
  endtask

  initial begin
    rst = 1'b1;
    hdr.valid = 1'b0;
    hdr.station_id = '0;
    hdr.board_id = '0;
    hdr.channel_id = '0;
    hdr.sample_freq_mhz = '0;
    hdr.time_seconds = '0;
    hdr.sample_nr = '0;
    hdr.freq_bands = '0;
    hdr.payload_bytes = '0;
    res.ready = 1'b0;
    cfg.valid = 1'b0;
    cfg.data = '0;
    hdr_idle = 0;
    res_idle = 20;
    sent = 0;
    masks_written = 0;
    stall_cycles = 0;
    now_sec = $urandom;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    write_mask('0);
    send_frame(make_frame(8'd0, 4'd0, 3'd0, 10'd200, 32'd100, 32'd1, 16'd0, 13'd100));
    drain(8);
    write_mask(~(64'd1 << 5));
    send_frame(make_frame(8'd0, 4'd0, 3'd0, 10'd200, 32'd101, 32'd1000, 16'd0, 13'd1030));
    send_frame(make_frame(8'd0, 4'd0, 3'd0, 10'd200, 32'd102, 32'd0, 16'd0, 13'd1030));
    send_frame(make_frame(8'd0, 4'd0, 3'd0, 10'd200, 32'd100, 32'd5000, 16'd0, 13'd1030));
    send_frame(make_frame(8'd0, 4'd0, 3'd0, 10'd200, 32'd101, 32'd999, 16'd0, 13'd1030));
    send_frame(make_frame(8'd0, 4'd15, 3'd7, 10'd200, 32'd50, 32'd7, 16'd0, 13'd1030));
    send_frame(make_frame(8'd0, 4'd0, 3'd0, 10'd200, 32'd51, 32'd8, 16'd0, 13'd1030));
    send_frame(make_frame(8'd0, 4'd0, 3'd0, 10'd200, 32'd53, 32'd12345, 16'd1, 13'd2));
    send_frame(make_frame(8'd0, 4'd0, 3'd0, 10'd200, 32'd53, 32'd12345, 16'd1, 13'd1));
    send_frame(make_frame(8'd0, 4'd0, 3'd0, 10'd200, 32'd53, 32'd1, 16'd0, 13'd5));
    send_frame(make_frame(8'd0, 4'd0, 3'd0, 10'd200, 32'd53, 32'd1, 16'd0, 13'd0));
    send_frame(make_frame(8'd0, 4'd0, 3'd0, 10'd200, 32'd53, 32'd1, 16'd0, 13'd6));
    send_frame(make_frame(8'd0, 4'd0, 3'd0, 10'd200, 32'd54, 32'd1, 16'd0, 13'd8191));
    send_frame(make_frame(8'd5, 4'd0, 3'd0, 10'd200, 32'd54, 32'd1, 16'd0, 13'd1030));
    send_frame(make_frame(8'd64, 4'd0, 3'd0, 10'd200, 32'd54, 32'd1, 16'd0, 13'd1030));
    send_frame(make_frame('1, '1, '1, '1, '1, '1, '1, '1));
    send_frame(make_frame(8'd63, 4'd15, 3'd7, '1, 32'd0, 32'd0, 16'd0, 13'd1000));
    send_frame(make_frame(8'd63, 4'd15, 3'd7, '1, '1, '1, 16'd0, 13'd1000));
    send_frame(make_frame(8'd1, 4'd3, 3'd2, 10'd200, 32'd1, '1, 16'd0, 13'd1030));
    send_frame(make_frame(8'd1, 4'd3, 3'd2, 10'd200, 32'd3, 32'hFFFF_FE00, 16'd0, 13'd1030));
    send_frame(make_frame(8'd62, 4'd0, 3'd0, 10'd0, 32'd5, 32'd9, 16'd0, 13'd200));
    send_frame(make_frame(8'd62, 4'd0, 3'd0, 10'd0, 32'd9, 32'd3, 16'd0, 13'd200));
    directed_count = sent;

    phase_mask[0] = '1;
    phase_mask[1] = {$urandom, $urandom} | 64'hFF;
    phase_mask[2] = 64'hAAAA_AAAA_AAAA_AAAA;
    for (int phase = 0; phase < 3; phase++) begin
      drain(8);
      write_mask(phase_mask[phase]);
      hdr_idle = (phase == 0) ? 9 : (phase == 1) ? 69 : 0;
      res_idle = (phase == 0) ? 69 : (phase == 1) ? 9 : 0;
      for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
        if (phase == 0 && i == 150) drain(0);
        send_frame(random_frame());
      end
    end

    hdr.valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("Run covered %0d headers (%0d directed) under %0d mask settings and three idling mixes.",
             sent, directed_count, masks_written);
    $display("Checked %0d results: %0d opened a stream, %0d had a negative offset.",
             checked, fresh_streams, negatives);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
